>>> rtl/mips_subset_execute_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MIPS subset execute core
// Shared wrappers so that every concurrent check is clocked alike on aclk.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_CORE_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_CORE_ASSERT_SVH

// Check clocked on aclk, ignored while aresetn is low.
`define MSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check clocked on aclk that also holds during reset.
`define MSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset execute package
// Shared widths, instruction encodings, status codes and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

    localparam int XLEN     = 32;
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    // Decode masks.
    localparam logic [31:0] MASK_R   = 32'hFC0007FF;
    localparam logic [31:0] MASK_OP  = 32'hFC000000;
    localparam logic [31:0] MASK_LUI = 32'hFFE00000;

    // Match values after masking.
    localparam logic [31:0] MATCH_ADD     = 32'h00000020;
    localparam logic [31:0] MATCH_SUB     = 32'h00000022;
    localparam logic [31:0] MATCH_AND     = 32'h00000024;
    localparam logic [31:0] MATCH_OR      = 32'h00000025;
    localparam logic [31:0] MATCH_SLT     = 32'h0000002A;
    localparam logic [31:0] MATCH_SYSCALL = 32'h0000000C;
    localparam logic [31:0] MATCH_MUL     = 32'h70000002;
    localparam logic [31:0] MATCH_ORI     = 32'h34000000;
    localparam logic [31:0] MATCH_LUI     = 32'h3C000000;
    localparam logic [31:0] MATCH_ANDI    = 32'h30000000;
    localparam logic [31:0] MATCH_SLTI    = 32'h28000000;
    localparam logic [31:0] MATCH_ADDI    = 32'h20000000;
    localparam logic [31:0] MATCH_BNE     = 32'h14000000;
    localparam logic [31:0] MATCH_BEQ     = 32'h10000000;

    // Syscall service codes found in register 2.
    localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [31:0] SYS_EXIT       = 32'd10;
    localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

    // Registers with a dedicated role in syscalls.
    localparam logic [RF_AW-1:0] REG_ZERO = RF_AW'(0);
    localparam logic [RF_AW-1:0] REG_V0   = RF_AW'(2);
    localparam logic [RF_AW-1:0] REG_A0   = RF_AW'(4);

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_INVALID         = 3'd1,
        ST_PRINT_INT       = 3'd2,
        ST_PRINT_CHAR      = 3'd3,
        ST_EXIT            = 3'd4,
        ST_UNKNOWN_SYSCALL = 3'd5
    } status_t;

    // Register file write from the execute stage.
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [XLEN-1:0]  data;
    } rf_wr_t;

    // One executed instruction's result.
    typedef struct packed {
        status_t          status;
        logic [15:0]      pc_step;
        logic [XLEN-1:0]  print_value;
        logic [XLEN-1:0]  syscall_number;
        logic             dest_write;
        logic [RF_AW-1:0] dest_reg;
        logic [XLEN-1:0]  dest_value;
    } exec_t;

endpackage

`default_nettype wire

>>> rtl/mips_subset_execute_core.sv
// ----------------------------------------------------------------------------
// MIPS subset execute core
// Executes one MIPS32 instruction word per beat against its register file.
// ----------------------------------------------------------------------------
// The core takes one instruction beat per clock while the result channel is not
// stalled and returns one result beat per instruction, in order. An accepted
// instruction sits in the input register while its two source registers are
// read from the register file RAMs; then decode, the ALU or 32x32 multiplier,
// and the register write happen together and the result lands in the output
// register. The sustained rate of one instruction per cycle is set by the
// single execute stage and the register file's one write port; a result
// written on the same edge that the next instruction reads is forwarded to
// it. The register file reads as zero after reset with no clearing pass.
`default_nettype none
`include "mips_subset_execute_core_assert.svh"

module mips_subset_execute_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,  // [31:0] instr_word
    // Result channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata   // [2:0] status, [18:3] pc_step,
                                        // [50:19] print_value,
                                        // [82:51] syscall_number,
                                        // [83] dest_write, [88:84] dest_reg,
                                        // [120:89] dest_value, rest zero
);
    import mse_pkg::*;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic [31:0]     instr_reg;
    logic            m_valid_reg;
    logic            m_valid_next;
    exec_t           out_reg;
    exec_t           exec_res;
    logic            advance;
    logic            accept;
    rf_wr_t          rf_wr;
    logic [XLEN-1:0] rs_data;
    logic [XLEN-1:0] rt_data;
    logic [XLEN-1:0] v0_data;
    logic [XLEN-1:0] a0_data;

    // Handshake: execute when the output slot is free or being drained.
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Register file, read as the beat is accepted.
    assign rf_wr.en   = advance && exec_res.dest_write;
    assign rf_wr.addr = exec_res.dest_reg;
    assign rf_wr.data = exec_res.dest_value;

    mse_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rs_addr (s_tdata[25:21]),
        .rt_addr (s_tdata[20:16]),
        .wr      (rf_wr),
        .rs_data (rs_data),
        .rt_data (rt_data),
        .v0_data (v0_data),
        .a0_data (a0_data)
    );

    // Decode and execute the held instruction.
    mse_exec u_exec (
        .instr   (instr_reg),
        .rs_data (rs_data),
        .rt_data (rt_data),
        .v0_data (v0_data),
        .a0_data (a0_data),
        .result  (exec_res)
    );

    // Next-state logic for the two valid flags.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            instr_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= exec_res;
        end
    end

    // Result beat packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, out_reg.dest_value, out_reg.dest_reg,
                       out_reg.dest_write, out_reg.syscall_number,
                       out_reg.print_value, out_reg.pc_step, out_reg.status};

    // A beat taken in is held in the input register on the next cycle.
    `MSE_ASSERT(a_accept_fills, accept |=> s1_valid_reg, "accepted beat was not captured")
    // A new result only appears after an instruction executed.
    `MSE_ASSERT(a_result_source, $rose(m_valid_reg) |-> $past(advance), "result without execute")
    // Register 0 is never the target of a write.
    `MSE_ASSERT(a_no_zero_write, rf_wr.en |-> rf_wr.addr != REG_ZERO, "write to register 0")
    // A beat reporting no write carries zero destination fields.
    `MSE_ASSERT(a_nowrite_zero, m_valid_reg && !out_reg.dest_write |-> out_reg.dest_reg == REG_ZERO && out_reg.dest_value == '0, "stray destination fields")
    // Failing and syscall statuses never come with a register write.
    `MSE_ASSERT(a_status_nowrite, m_valid_reg && out_reg.status != ST_OK |-> !out_reg.dest_write, "write with non-ok status")
    // Control is idle coming out of reset.
    `MSE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !s1_valid_reg && !m_valid_reg, "not idle after reset")

endmodule

`default_nettype wire

>>> rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; returns the old contents when it collides with a write.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/mse_regfile.sv
// ----------------------------------------------------------------------------
// Register file
// Two read ports into RAM copies, per-entry valid bits for the zero reset,
// same-edge write forwarding, and flop copies of registers 2 and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_regfile (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rd_en,
    input  wire logic [mse_pkg::RF_AW-1:0]     rs_addr,
    input  wire logic [mse_pkg::RF_AW-1:0]     rt_addr,
    input  wire mse_pkg::rf_wr_t               wr,
    output logic      [mse_pkg::XLEN-1:0]      rs_data,
    output logic      [mse_pkg::XLEN-1:0]      rt_data,
    output logic      [mse_pkg::XLEN-1:0]      v0_data,
    output logic      [mse_pkg::XLEN-1:0]      a0_data
);
    import mse_pkg::*;

    logic [RF_DEPTH-1:0] valid_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic                fwd_a_reg;
    logic                fwd_b_reg;
    logic [XLEN-1:0]     fwd_data_reg;
    logic [XLEN-1:0]     v0_reg;
    logic [XLEN-1:0]     a0_reg;
    logic [XLEN-1:0]     ram_a;
    logic [XLEN-1:0]     ram_b;

    // One RAM copy per read port, both written alike.
    mse_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rs_addr),
        .rdata (ram_a)
    );

    mse_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rt_addr),
        .rdata (ram_b)
    );

    // Valid bits: an entry never written reads as zero, and register 0 never gets one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Capture valid and forwarding info alongside the RAM read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            vld_a_reg    <= valid_reg[rs_addr];
            vld_b_reg    <= valid_reg[rt_addr];
            fwd_a_reg    <= wr.en && (wr.addr == rs_addr);
            fwd_b_reg    <= wr.en && (wr.addr == rt_addr);
            fwd_data_reg <= wr.data;
        end
    end

    // Flop copies of the syscall registers, always current.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= '0;
            a0_reg <= '0;
        end else if (wr.en) begin
            if (wr.addr == REG_V0) begin
                v0_reg <= wr.data;
            end
            if (wr.addr == REG_A0) begin
                a0_reg <= wr.data;
            end
        end
    end

    // Operand selection: forwarded value, stored value or reset zero.
    always_comb begin
        if (fwd_a_reg) begin
            rs_data = fwd_data_reg;
        end else if (vld_a_reg) begin
            rs_data = ram_a;
        end else begin
            rs_data = '0;
        end
        if (fwd_b_reg) begin
            rt_data = fwd_data_reg;
        end else if (vld_b_reg) begin
            rt_data = ram_b;
        end else begin
            rt_data = '0;
        end
    end

    assign v0_data = v0_reg;
    assign a0_data = a0_reg;

endmodule

`default_nettype wire

>>> rtl/mse_exec.sv
// ----------------------------------------------------------------------------
// Decode and execute
// Matches the instruction word against the supported encodings and forms
// the status, program-counter step and register write in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_exec (
    input  wire logic [31:0]              instr,
    input  wire logic [mse_pkg::XLEN-1:0] rs_data,
    input  wire logic [mse_pkg::XLEN-1:0] rt_data,
    input  wire logic [mse_pkg::XLEN-1:0] v0_data,
    input  wire logic [mse_pkg::XLEN-1:0] a0_data,
    output mse_pkg::exec_t                result
);
    import mse_pkg::*;

    logic [RF_AW-1:0] rt;
    logic [RF_AW-1:0] rd;
    logic [15:0]      imm;
    logic [XLEN-1:0]  zimm;
    logic [XLEN-1:0]  simm;
    logic [31:0]      r_key;
    logic [31:0]      op_key;
    logic [XLEN-1:0]  product;
    logic             wr;
    logic [RF_AW-1:0] dst;
    logic [XLEN-1:0]  val;

    assign rt      = instr[20:16];
    assign rd      = instr[15:11];
    assign imm     = instr[15:0];
    assign zimm    = {16'h0000, imm};
    assign simm    = {{16{imm[15]}}, imm};
    assign r_key   = instr & MASK_R;
    assign op_key  = instr & MASK_OP;
    assign product = rs_data * rt_data;

    // Priority decode in the architectural match order.
    always_comb begin
        result.status         = ST_OK;
        result.pc_step        = 16'd1;
        result.print_value    = '0;
        result.syscall_number = '0;
        wr                    = 1'b0;
        dst                   = REG_ZERO;
        val                   = '0;
        if (r_key == MATCH_ADD) begin
            wr = 1'b1; dst = rd; val = rs_data + rt_data;
        end else if (r_key == MATCH_SUB) begin
            wr = 1'b1; dst = rd; val = rs_data - rt_data;
        end else if (r_key == MATCH_AND) begin
            wr = 1'b1; dst = rd; val = rs_data & rt_data;
        end else if (r_key == MATCH_OR) begin
            wr = 1'b1; dst = rd; val = rs_data | rt_data;
        end else if (r_key == MATCH_SLT) begin
            wr = 1'b1; dst = rd;
            val = XLEN'($signed(rs_data) < $signed(rt_data));
        end else if (instr == MATCH_SYSCALL) begin
            result.syscall_number = v0_data;
            if (v0_data == SYS_PRINT_INT) begin
                result.status      = ST_PRINT_INT;
                result.print_value = a0_data;
            end else if (v0_data == SYS_EXIT) begin
                result.status = ST_EXIT;
            end else if (v0_data == SYS_PRINT_CHAR) begin
                result.status      = ST_PRINT_CHAR;
                result.print_value = a0_data;
            end else begin
                result.status = ST_UNKNOWN_SYSCALL;
            end
        end else if (r_key == MATCH_MUL) begin
            wr = 1'b1; dst = rd; val = product;
        end else if (op_key == MATCH_ORI) begin
            wr = 1'b1; dst = rt; val = rs_data | zimm;
        end else if ((instr & MASK_LUI) == MATCH_LUI) begin
            wr = 1'b1; dst = rt; val = {imm, 16'h0000};
        end else if (op_key == MATCH_ANDI) begin
            wr = 1'b1; dst = rt; val = rs_data & zimm;
        end else if (op_key == MATCH_SLTI) begin
            wr = 1'b1; dst = rt;
            val = XLEN'($signed(rs_data) < $signed(simm));
        end else if (op_key == MATCH_ADDI) begin
            wr = 1'b1; dst = rt; val = rs_data + simm;
        end else if (op_key == MATCH_BNE) begin
            if (rs_data != rt_data) begin
                result.pc_step = imm;
            end
        end else if (op_key == MATCH_BEQ) begin
            if (rs_data == rt_data) begin
                result.pc_step = imm;
            end
        end else begin
            result.status = ST_INVALID;
        end

        // A write to register 0 is dropped and reported as no write.
        if (wr && (dst != REG_ZERO)) begin
            result.dest_write = 1'b1;
            result.dest_reg   = dst;
            result.dest_value = val;
        end else begin
            result.dest_write = 1'b0;
            result.dest_reg   = REG_ZERO;
            result.dest_value = '0;
        end
    end

endmodule

`default_nettype wire

>>> dv/mips_subset_execute_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS subset execute core testbench
// Feeds instruction beats and checks every result beat against a shadow
// register file and decoder kept inside the bench, under random back-pressure.
// ----------------------------------------------------------------------------
module mips_subset_execute_core_tb;

    import mse_pkg::*;

    typedef struct {
        logic [31:0] word;
        bit          drain_first;
    } pending_t;

    localparam int CLK_HALF = 4;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    // Instructions waiting to be sent and retirements waiting to be seen.
    pending_t     instr_q[$];
    exec_t        retire_q[$];

    // Shadow architectural register file.
    logic [31:0]  arch_gpr[RF_DEPTH];

    int           words_total   = 0;
    int           accepted_cnt  = 0;
    int           results_seen  = 0;
    int           mismatches    = 0;
    int           send_gap      = 0;
    int           hold_left     = 0;
    bit           long_hold_done = 1'b0;

    mips_subset_execute_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] instr_word
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [2:0] status, [18:3] pc_step, [50:19] print_value,
                               // [82:51] syscall_number, [83] dest_write,
                               // [88:84] dest_reg, [120:89] dest_value
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard limit on the run time.
    initial begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Encoders for the two instruction formats.
    function automatic logic [31:0] enc_r(input logic [31:0] match, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd);
        return match | {6'b0, rs, rt, rd, 11'b0};
    endfunction

    function automatic logic [31:0] enc_i(input logic [31:0] match, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return match | {6'b0, rs, rt, imm};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favor the low registers so that written values get read back.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Decode and execute one word on the shadow register file.
    function automatic exec_t execute_word(input logic [31:0] w);
        exec_t       res;
        logic [4:0]  rs, rt, rd, dst;
        logic [15:0] imm;
        logic [31:0] simm, a, b, val, code;
        bit          wr;
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        imm  = w[15:0];
        simm = {{16{imm[15]}}, imm};
        a    = arch_gpr[rs];
        b    = arch_gpr[rt];
        wr   = 1'b0;
        dst  = '0;
        val  = '0;
        res  = '0;
        res.status  = ST_OK;
        res.pc_step = 16'd1;
        if ((w & MASK_R) == MATCH_ADD) begin
            wr = 1'b1; dst = rd; val = a + b;
        end else if ((w & MASK_R) == MATCH_SUB) begin
            wr = 1'b1; dst = rd; val = a - b;
        end else if ((w & MASK_R) == MATCH_AND) begin
            wr = 1'b1; dst = rd; val = a & b;
        end else if ((w & MASK_R) == MATCH_OR) begin
            wr = 1'b1; dst = rd; val = a | b;
        end else if ((w & MASK_R) == MATCH_SLT) begin
            wr = 1'b1; dst = rd; val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end else if (w == MATCH_SYSCALL) begin
            code = arch_gpr[REG_V0];
            res.syscall_number = code;
            if (code == SYS_PRINT_INT) begin
                res.status = ST_PRINT_INT;
                res.print_value = arch_gpr[REG_A0];
            end else if (code == SYS_EXIT) begin
                res.status = ST_EXIT;
            end else if (code == SYS_PRINT_CHAR) begin
                res.status = ST_PRINT_CHAR;
                res.print_value = arch_gpr[REG_A0];
            end else begin
                res.status = ST_UNKNOWN_SYSCALL;
            end
        end else if ((w & MASK_R) == MATCH_MUL) begin
            wr = 1'b1; dst = rd; val = a * b;
        end else if ((w & MASK_OP) == MATCH_ORI) begin
            wr = 1'b1; dst = rt; val = a | {16'b0, imm};
        end else if ((w & MASK_LUI) == MATCH_LUI) begin
            wr = 1'b1; dst = rt; val = {imm, 16'b0};
        end else if ((w & MASK_OP) == MATCH_ANDI) begin
            wr = 1'b1; dst = rt; val = a & {16'b0, imm};
        end else if ((w & MASK_OP) == MATCH_SLTI) begin
            wr = 1'b1; dst = rt; val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        end else if ((w & MASK_OP) == MATCH_ADDI) begin
            wr = 1'b1; dst = rt; val = a + simm;
        end else if ((w & MASK_OP) == MATCH_BNE) begin
            if (a != b) res.pc_step = imm;
        end else if ((w & MASK_OP) == MATCH_BEQ) begin
            if (a == b) res.pc_step = imm;
        end else begin
            res.status = ST_INVALID;
        end
        // Writes to register zero are dropped and not reported.
        if (wr && dst != REG_ZERO) begin
            arch_gpr[dst]  = val;
            res.dest_write = 1'b1;
            res.dest_reg   = dst;
            res.dest_value = val;
        end
        return res;
    endfunction

    task automatic add_word(input logic [31:0] w, input bit drain_first = 1'b0);
        pending_t p;
        p.word        = w;
        p.drain_first = drain_first;
        instr_q.push_back(p);
        words_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Sender: predicts each accepted beat and offers the next one.
    always @(posedge aclk) begin : drive
        pending_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                retire_q.push_back(execute_word(s_tdata));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (s_tvalid && !s_tready) begin
                // Hold the beat until it is taken.
            end else if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (instr_q.size() != 0 &&
                         !(instr_q[0].drain_first && retire_q.size() != 0)) begin
                next_item = instr_q.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= next_item.word;
                // Some stretches run with no gaps at all.
                send_gap  <= ((accepted_cnt % 200) >= 150) ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold to fill the core.
    always @(posedge aclk) begin : backpressure
        int gap;
        if (!aresetn) begin
            m_tready       <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 300) begin
            m_tready       <= 1'b0;
            hold_left      <= 200;
            long_hold_done <= 1'b1;
        end else if ((results_seen % 256) < 64) begin
            m_tready <= 1'b1;
        end else begin
            gap = pick_gap();
            m_tready  <= (gap == 0);
            hold_left <= (gap == 0) ? 0 : gap - 1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin : check
        exec_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (retire_q.size() == 0) begin
                $error("result beat with no instruction outstanding: %h", m_tdata);
                mismatches++;
            end else begin
                exp_r = retire_q.pop_front();
                check_field("status", 32'(exp_r.status), 32'(m_tdata[2:0]));
                check_field("pc_step", 32'(exp_r.pc_step), 32'(m_tdata[18:3]));
                check_field("print_value", exp_r.print_value, m_tdata[50:19]);
                check_field("syscall_number", exp_r.syscall_number, m_tdata[82:51]);
                check_field("dest_write", 32'(exp_r.dest_write), 32'(m_tdata[83]));
                check_field("dest_reg", 32'(exp_r.dest_reg), 32'(m_tdata[88:84]));
                check_field("dest_value", exp_r.dest_value, m_tdata[120:89]);
                check_field("padding", 32'd0, 32'(m_tdata[127:121]));
            end
        end
    end

    // Stimulus, then wait for every result and report.
    initial begin : stimulus
        logic [31:0] r_ops[6];
        logic [31:0] i_ops[6];
        logic [31:0] w;
        logic [4:0]  rs, rt;
        int          r;
        r_ops = '{MATCH_ADD, MATCH_SUB, MATCH_AND, MATCH_OR, MATCH_SLT, MATCH_MUL};
        i_ops = '{MATCH_ORI, MATCH_ANDI, MATCH_SLTI, MATCH_ADDI, MATCH_BNE, MATCH_BEQ};
        foreach (arch_gpr[i]) arch_gpr[i] = '0;

        // Directed: unrecognized extremes of the word.
        add_word(32'h0000_0000);
        add_word(32'hFFFF_FFFF);
        // Immediate forms: lui raw, ori and andi zero-extended, addi sign-extended.
        add_word(enc_i(MATCH_LUI, 5'd0, 5'd1, 16'h8000));
        add_word(enc_i(MATCH_ORI, 5'd1, 5'd1, 16'hFFFF));
        add_word(enc_i(MATCH_ADDI, 5'd0, 5'd2, 16'hFFFF));
        add_word(enc_i(MATCH_ANDI, 5'd2, 5'd3, 16'h8001));
        // Register forms with wrap, signed compare and a truncated product.
        add_word(enc_r(MATCH_ADD, 5'd1, 5'd2, 5'd4));
        add_word(enc_r(MATCH_SUB, 5'd0, 5'd1, 5'd5));
        add_word(enc_r(MATCH_AND, 5'd1, 5'd2, 5'd6));
        add_word(enc_r(MATCH_OR, 5'd3, 5'd1, 5'd7));
        add_word(enc_r(MATCH_SLT, 5'd1, 5'd3, 5'd8));
        add_word(enc_i(MATCH_SLTI, 5'd3, 5'd9, 16'h7FFF));
        add_word(enc_r(MATCH_MUL, 5'd1, 5'd2, 5'd10));
        // A write to register zero is dropped.
        add_word(enc_i(MATCH_ADDI, 5'd2, 5'd0, 16'h0005));
        // Branch taken with zero offset, taken backwards, and two not taken.
        add_word(enc_i(MATCH_BEQ, 5'd0, 5'd0, 16'h0000));
        add_word(enc_i(MATCH_BNE, 5'd1, 5'd2, 16'h8000));
        add_word(enc_i(MATCH_BEQ, 5'd1, 5'd2, 16'h0007));
        add_word(enc_i(MATCH_BNE, 5'd3, 5'd3, 16'h0007));
        // Every syscall outcome.
        add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, SYS_PRINT_INT[15:0]));
        add_word(MATCH_SYSCALL);
        add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, SYS_PRINT_CHAR[15:0]));
        add_word(MATCH_SYSCALL);
        add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, SYS_EXIT[15:0]));
        add_word(MATCH_SYSCALL);
        add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, 16'hFFFF));
        add_word(MATCH_SYSCALL);
        // lui with a nonzero rs field is not a lui.
        add_word(enc_i(MATCH_LUI, 5'd3, 5'd11, 16'h1234));

        // Random: mostly well-formed instructions, some syscall sequences and noise.
        for (int n = 0; n < 900; n++) begin
            r = $urandom_range(0, 99);
            if (n == 0 || n == 450) begin
                // Let the core drain completely before this beat.
                add_word(enc_i(MATCH_ADDI, pick_reg(), pick_reg(), pick_imm()), 1'b1);
            end else if (r < 8) begin
                case ($urandom_range(0, 3))
                    0: add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, SYS_PRINT_INT[15:0]));
                    1: add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, SYS_PRINT_CHAR[15:0]));
                    2: add_word(enc_i(MATCH_ADDI, REG_ZERO, REG_V0, SYS_EXIT[15:0]));
                    default: begin
                        add_word(enc_i(MATCH_LUI, REG_ZERO, REG_V0, 16'($urandom)));
                        add_word(enc_i(MATCH_ORI, REG_V0, REG_V0, 16'($urandom)));
                    end
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    add_word(enc_i(MATCH_LUI, REG_ZERO, REG_A0, pick_imm()));
                    add_word(enc_i(MATCH_ORI, REG_A0, REG_A0, pick_imm()));
                end
                add_word(MATCH_SYSCALL);
            end else if (r < 13) begin
                add_word(32'($urandom));
            end else if (r < 17) begin
                case ($urandom_range(0, 2))
                    0: add_word(enc_r(r_ops[$urandom_range(0, 5)], pick_reg(), pick_reg(),
                                      pick_reg()) | (32'($urandom_range(1, 31)) << 6));
                    1: add_word(enc_i(MATCH_LUI, 5'($urandom_range(1, 31)), pick_reg(),
                                      pick_imm()));
                    default: add_word(MATCH_SYSCALL ^ (32'd1 << $urandom_range(0, 31)));
                endcase
            end else if (r < 55) begin
                add_word(enc_r(r_ops[$urandom_range(0, 5)], pick_reg(), pick_reg(),
                               pick_reg()));
            end else if (r < 65) begin
                add_word(enc_i(MATCH_LUI, REG_ZERO, pick_reg(), pick_imm()));
            end else begin
                w  = i_ops[$urandom_range(0, 5)];
                rs = pick_reg();
                rt = pick_reg();
                // Branches compare a register with itself half the time.
                if ((w == MATCH_BEQ || w == MATCH_BNE) && $urandom_range(0, 1) == 0)
                    rt = rs;
                add_word(enc_i(w, rs, rt, pick_imm()));
            end
        end

        // Wait until every beat is taken and every result has come back.
        do begin
            @(posedge aclk);
        end while (accepted_cnt != words_total || retire_q.size() != 0);
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_regfile.sv
rtl/mse_exec.sv
rtl/mips_subset_execute_core.sv
dv/mips_subset_execute_core_tb.sv
